@@ design/arith_encoder_e1e2_scaling_macros.svh @@
// Assertion macros for the arithmetic encoder with E1/E2 scaling.
// Included by the top level only; needs a clock and an active-low reset name.
`ifndef ARITH_ENCODER_E1E2_SCALING_MACROS_SVH
`define ARITH_ENCODER_E1E2_SCALING_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AENC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AENC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/aenc_pkg.sv @@
// Shared constants, types and the CDF selection function of the arithmetic encoder.
// No dependencies; every module of the block imports this package.
package aenc_pkg;

    localparam int FRACTION_BITS = 24;
    localparam int MAX_SYMBOLS   = 7;
    localparam int MAX_RESULTS   = 24;

    localparam int BOUND_W  = FRACTION_BITS + 1;
    localparam int CDF_W    = 17;
    localparam int CDF_FRAC = 16;
    localparam int PROD_W   = BOUND_W + CDF_W;
    localparam int SYM_W    = 3;
    localparam int COUNT_W  = $clog2(MAX_RESULTS + 1);
    localparam int REG_IDX_W = 3;
    localparam int TDATA_W  = 8;

    localparam logic [BOUND_W-1:0] BOUND_ONE  = BOUND_W'(1) << FRACTION_BITS;
    localparam logic [BOUND_W-1:0] BOUND_HALF = BOUND_W'(1) << (FRACTION_BITS - 1);
    localparam logic [CDF_W-1:0]   CDF_ONE    = CDF_W'(1) << CDF_FRAC;

    // Result status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_SYM  = 2'd1;
    localparam logic [1:0] STATUS_COLLAPSE = 2'd2;

    // Configuration register indexes.
    localparam logic [REG_IDX_W-1:0] REG_NUM_SYMBOLS = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CDF_ONE     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CDF_TWO     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CDF_THREE   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CDF_FOUR    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_CDF_FIVE    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_CDF_SIX     = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_CDF_SEVEN   = 3'd7;

    typedef struct packed {
        logic [SYM_W-1:0] num_symbols;
        logic [CDF_W-1:0] cdf_one;
        logic [CDF_W-1:0] cdf_two;
        logic [CDF_W-1:0] cdf_three;
        logic [CDF_W-1:0] cdf_four;
        logic [CDF_W-1:0] cdf_five;
        logic [CDF_W-1:0] cdf_six;
        logic [CDF_W-1:0] cdf_seven;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // take the input item
        logic mul;      // form range times both CDF bounds
        logic narrow;   // add the scaled products to the low bound
        logic emit;     // load one result into the output register
    } aenc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free; // output register can take a result this cycle
        logic final_res; // the result about to be emitted is the item's last
    } aenc_stat_t;

    // Cumulative probability through symbol k, saturated to one; zero below symbol 1.
    function automatic logic [CDF_W-1:0] cdf_pick(input cfg_t cfg, input logic [SYM_W-1:0] k);
        logic [CDF_W-1:0] v;
        unique case (k)
            3'd1:    v = cfg.cdf_one;
            3'd2:    v = cfg.cdf_two;
            3'd3:    v = cfg.cdf_three;
            3'd4:    v = cfg.cdf_four;
            3'd5:    v = cfg.cdf_five;
            3'd6:    v = cfg.cdf_six;
            3'd7:    v = cfg.cdf_seven;
            default: v = '0;
        endcase
        return (v > CDF_ONE) ? CDF_ONE : v;
    endfunction

endpackage

@@ design/arith_encoder_e1e2_scaling.sv @@
// Top level of the arithmetic-coding encoder with E1/E2 interval scaling.
// Depends on aenc_pkg, aenc_cfg, aenc_ctrl, aenc_dp and the assertion macro header.
//
//  Channel   Direction  Handshake            Payload
//  s_        in         s_tvalid/s_tready    s_tdata: symbol; s_tuser: start_message
//  m_        out        m_tvalid/m_tready    m_tdata: code_bit; m_tuser: bit_present,
//                                            status; m_tlast: last_of_symbol
//  cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// An item passes through accept, the two range-by-CDF multipliers and the bound adders,
// then gives n results (one per emitted bit, at least one) through the output register.
// A held m_tready stretches the result phase; the next item is taken while the last result
// still waits. After reset the interval is [0, 1), three symbols are in use and every
// CDF word is one.
`include "arith_encoder_e1e2_scaling_macros.svh"

module arith_encoder_e1e2_scaling import aenc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [TDATA_W-1:0]   s_tdata,   // [2:0] symbol, upper bits zero
    input  logic [0:0]           s_tuser,   // [0] start_message
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata,   // [0] code_bit, upper bits zero
    output logic [2:0]           m_tuser,   // [0] bit_present, [2:1] status
    output logic                 m_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CDF_W-1:0]     cfg_data
);

    cfg_t       cfg;
    aenc_cmd_t  cmd;
    aenc_stat_t stat;
    logic       code_bit;
    logic       bit_present;
    logic [1:0] status;

    // Configuration registers; writes must arrive only while the encoder is idle; the block does not check it.
    aenc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The controller sequences accept, multiply, narrow and one result per cycle while the output register is free.
    aenc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the interval, the working bounds and the output register.
    aenc_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .cmd             (cmd),
        .stat            (stat),
        .in_symbol       (s_tdata[SYM_W-1:0]),
        .in_start        (s_tuser[0]),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_code_bit    (code_bit),
        .out_bit_present (bit_present),
        .out_last        (m_tlast),
        .out_status      (status)
    );

    assign m_tdata = {{(TDATA_W - 1){1'b0}}, code_bit};
    assign m_tuser = {status, bit_present};

    // A result that carries no bit always closes its item.
    `AENC_ASSERT_NOW(a_nobit_is_last, aclk, aresetn, m_tvalid && !m_tuser[0], m_tlast,
        "result without a bit is not marked last")

    // Error results carry no bit and close the item.
    `AENC_ASSERT_NOW(a_error_alone, aclk, aresetn,
        m_tvalid && (m_tuser[2:1] != STATUS_OK), !m_tuser[0] && m_tlast,
        "error result carries a bit or is not last")

    // After an item is taken the encoder is busy for at least the multiply cycle.
    `AENC_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready,
        "input accepted again in the cycle after an accept")

endmodule

@@ design/aenc_cfg.sv @@
// Configuration register file of the arithmetic encoder.
// Depends on aenc_pkg for the register indexes and the cfg_t type.
module aenc_cfg import aenc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CDF_W-1:0]     cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_NUM_SYMBOLS: cfg_next.num_symbols = cfg_data[SYM_W-1:0];
                REG_CDF_ONE:     cfg_next.cdf_one     = cfg_data;
                REG_CDF_TWO:     cfg_next.cdf_two     = cfg_data;
                REG_CDF_THREE:   cfg_next.cdf_three   = cfg_data;
                REG_CDF_FOUR:    cfg_next.cdf_four    = cfg_data;
                REG_CDF_FIVE:    cfg_next.cdf_five    = cfg_data;
                REG_CDF_SIX:     cfg_next.cdf_six     = cfg_data;
                REG_CDF_SEVEN:   cfg_next.cdf_seven   = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.num_symbols <= SYM_W'(3);
            cfg_reg.cdf_one     <= CDF_ONE;
            cfg_reg.cdf_two     <= CDF_ONE;
            cfg_reg.cdf_three   <= CDF_ONE;
            cfg_reg.cdf_four    <= CDF_ONE;
            cfg_reg.cdf_five    <= CDF_ONE;
            cfg_reg.cdf_six     <= CDF_ONE;
            cfg_reg.cdf_seven   <= CDF_ONE;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ design/aenc_dp.sv @@
// Datapath of the arithmetic encoder: interval bounds, multipliers, scaling and output register.
// Depends on aenc_pkg; driven by commands from aenc_ctrl.
module aenc_dp import aenc_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  cfg_t             cfg,
    input  aenc_cmd_t        cmd,
    output aenc_stat_t       stat,
    input  logic [SYM_W-1:0] in_symbol,
    input  logic             in_start,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             out_code_bit,
    output logic             out_bit_present,
    output logic             out_last,
    output logic [1:0]       out_status
);

    logic [BOUND_W-1:0] low_reg, low_next;
    logic [BOUND_W-1:0] high_reg, high_next;
    logic [SYM_W-1:0]   sym_reg, sym_next;
    logic [PROD_W-1:0]  prod_lo_reg, prod_lo_next;
    logic [PROD_W-1:0]  prod_hi_reg, prod_hi_next;
    logic [BOUND_W-1:0] lo_reg, lo_next;
    logic [BOUND_W-1:0] hi_reg, hi_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               valid_reg, valid_next;
    logic               bit_reg, bit_next;
    logic               present_reg, present_next;
    logic               last_reg, last_next;
    logic [1:0]         status_reg, status_next;

    logic [SYM_W-1:0]   limit;
    logic               bad_sym;
    logic               collapse;
    logic               e1, e2, scale, more;
    logic [BOUND_W-1:0] range_w, step_lo, step_hi;
    logic               out_free;

    assign limit    = (cfg.num_symbols > SYM_W'(MAX_SYMBOLS)) ? SYM_W'(MAX_SYMBOLS)
                                                               : cfg.num_symbols;
    assign bad_sym  = (sym_reg == '0) || (sym_reg > limit);
    assign collapse = (hi_reg <= lo_reg);
    assign e1       = (hi_reg <= BOUND_HALF);
    assign e2       = (lo_reg >= BOUND_HALF);
    assign scale    = e1 || e2;
    assign range_w  = high_reg - low_reg;

    // E1 takes priority: both bounds double; E2 drops half first.
    always_comb begin
        if (e1) begin
            step_lo = lo_reg << 1;
            step_hi = hi_reg << 1;
        end else begin
            step_lo = (lo_reg - BOUND_HALF) << 1;
            step_hi = (hi_reg - BOUND_HALF) << 1;
        end
    end

    assign more = ((step_hi <= BOUND_HALF) || (step_lo >= BOUND_HALF))
                  && (count_reg < COUNT_W'(MAX_RESULTS - 1));

    assign out_free       = !valid_reg || out_ready;
    assign stat.out_free  = out_free;
    assign stat.final_res = bad_sym || collapse || !scale || !more;

    always_comb begin
        low_next     = low_reg;
        high_next    = high_reg;
        sym_next     = sym_reg;
        prod_lo_next = prod_lo_reg;
        prod_hi_next = prod_hi_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        count_next   = count_reg;
        valid_next   = valid_reg && !out_ready;
        bit_next     = bit_reg;
        present_next = present_reg;
        last_next    = last_reg;
        status_next  = status_reg;

        if (cmd.load) begin
            sym_next   = in_symbol;
            count_next = '0;
            if (in_start) begin
                low_next  = '0;
                high_next = BOUND_ONE;
            end
        end

        if (cmd.mul) begin
            prod_lo_next = PROD_W'(range_w) * PROD_W'(cdf_pick(cfg, sym_reg - SYM_W'(1)));
            prod_hi_next = PROD_W'(range_w) * PROD_W'(cdf_pick(cfg, sym_reg));
        end

        if (cmd.narrow) begin
            lo_next = low_reg + BOUND_W'(prod_lo_reg >> CDF_FRAC);
            hi_next = low_reg + BOUND_W'(prod_hi_reg >> CDF_FRAC);
        end

        if (cmd.emit) begin
            valid_next = 1'b1;
            bit_next   = 1'b0;
            if (bad_sym) begin
                present_next = 1'b0;
                last_next    = 1'b1;
                status_next  = STATUS_BAD_SYM;
            end else if (collapse) begin
                present_next = 1'b0;
                last_next    = 1'b1;
                status_next  = STATUS_COLLAPSE;
            end else if (scale) begin
                bit_next     = !e1;
                present_next = 1'b1;
                last_next    = !more;
                status_next  = STATUS_OK;
                lo_next      = step_lo;
                hi_next      = step_hi;
                count_next   = count_reg + COUNT_W'(1);
                if (!more) begin
                    low_next  = step_lo;
                    high_next = step_hi;
                end
            end else begin
                // Narrowed interval straddles the half point: nothing to emit.
                present_next = 1'b0;
                last_next    = 1'b1;
                status_next  = STATUS_OK;
                low_next     = lo_reg;
                high_next    = hi_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg   <= '0;
            high_reg  <= BOUND_ONE;
            valid_reg <= 1'b0;
        end else begin
            low_reg   <= low_next;
            high_reg  <= high_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sym_reg     <= sym_next;
        prod_lo_reg <= prod_lo_next;
        prod_hi_reg <= prod_hi_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        count_reg   <= count_next;
        bit_reg     <= bit_next;
        present_reg <= present_next;
        last_reg    <= last_next;
        status_reg  <= status_next;
    end

    assign out_valid       = valid_reg;
    assign out_code_bit    = bit_reg;
    assign out_bit_present = present_reg;
    assign out_last        = last_reg;
    assign out_status      = status_reg;

endmodule

@@ design/aenc_ctrl.sv @@
// Controller state machine of the arithmetic encoder.
// Depends on aenc_pkg for the command and status structs.
module aenc_ctrl import aenc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  aenc_stat_t stat,
    output aenc_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_MUL    = 2'd1;
    localparam logic [1:0] ST_NARROW = 2'd2;
    localparam logic [1:0] ST_SCALE  = 2'd3;

    logic [1:0] state_reg, state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_NARROW;
            end
            ST_NARROW: begin
                cmd.narrow = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    if (stat.final_res) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for arith_encoder_e1e2_scaling: stream driver, result monitor
// and a cycle-free predictor of the E1/E2 interval scaling. Needs aenc_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
    import aenc_pkg::*;

    // One symbol item as queued for the driver.
    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             start;
    } sym_item_t;

    // One result item as the encoder should emit it.
    typedef struct packed {
        logic       code_bit;
        logic       bit_present;
        logic       last_of_sym;
        logic [1:0] status;
    } code_result_t;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata   = '0;   // [2:0] symbol, upper bits zero
    logic [0:0]           s_tuser   = '0;   // [0] start_message
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;          // [0] code_bit, upper bits zero
    logic [2:0]           m_tuser;          // [0] bit_present, [2:1] status
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [REG_IDX_W-1:0] cfg_index = '0;
    logic [CDF_W-1:0]     cfg_data  = '0;

    sym_item_t    symbols_pending[$];
    code_result_t results_due[$];
    int           errors  = 0;
    bit           calm    = 1'b0;   // both sides run flat out while set
    bit           s_taken = 1'b0;

    // Private copy of the encoder interval and its settings.
    logic [BOUND_W-1:0] enc_low;
    logic [BOUND_W-1:0] enc_high;
    logic [SYM_W-1:0]   enc_num_syms;
    logic [CDF_W-1:0]   enc_cdf [1:7];

    // Settings that the stimulus is about to write.
    int plan_num;
    int plan_cdf [1:7];

    arith_encoder_e1e2_scaling i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // The slowest run is a few hundred items, stretched by stalls; this bound is many times that.
    initial begin
        #10_000_000;
        $display("arith_encoder_e1e2_scaling verification failed");
        $finish;
    end

    // Cumulative probability through symbol k, saturated to one; zero below symbol 1.
    function automatic logic [CDF_W-1:0] cum_prob(input int k);
        if (k < 1 || k > 7)
            return '0;
        return (enc_cdf[k] > CDF_ONE) ? CDF_ONE : enc_cdf[k];
    endfunction

    // Narrow the kept interval to the symbol's slice and queue the bits that the
    // E1/E2 rescaling emits.
    function automatic void encode_symbol(input logic [SYM_W-1:0] sym, input logic start);
        logic [BOUND_W-1:0] lo;
        logic [BOUND_W-1:0] hi;
        logic [PROD_W-1:0]  span;
        code_result_t       held;
        code_result_t       one_res;
        bit                 have;
        int                 n;
        int                 top;
        have = 1'b0;
        n    = 0;
        // The start mark takes effect even when the symbol is then refused.
        if (start) begin
            enc_low  = '0;
            enc_high = BOUND_ONE;
        end
        top = (enc_num_syms > MAX_SYMBOLS) ? MAX_SYMBOLS : enc_num_syms;
        if (sym == 0 || sym > top) begin
            one_res = '{1'b0, 1'b0, 1'b1, STATUS_BAD_SYM};
            results_due.push_back(one_res);
            return;
        end
        span = PROD_W'(enc_high - enc_low);
        lo = enc_low + BOUND_W'((span * cum_prob(sym - 1)) >> CDF_FRAC);
        hi = enc_low + BOUND_W'((span * cum_prob(sym)) >> CDF_FRAC);
        // An empty or reversed slice leaves the interval as it was.
        if (hi <= lo) begin
            one_res = '{1'b0, 1'b0, 1'b1, STATUS_COLLAPSE};
            results_due.push_back(one_res);
            return;
        end
        while (n < MAX_RESULTS) begin
            if (hi <= BOUND_HALF) begin
                one_res = '{1'b0, 1'b1, 1'b0, STATUS_OK};
                lo = lo << 1;
                hi = hi << 1;
            end else if (lo >= BOUND_HALF) begin
                one_res = '{1'b1, 1'b1, 1'b0, STATUS_OK};
                lo = (lo - BOUND_HALF) << 1;
                hi = (hi - BOUND_HALF) << 1;
            end else begin
                break;
            end
            // Hold each bit back one step so that the last one can be marked.
            if (have)
                results_due.push_back(held);
            held = one_res;
            have = 1'b1;
            n++;
        end
        enc_low  = lo;
        enc_high = hi;
        if (!have) begin
            one_res = '{1'b0, 1'b0, 1'b1, STATUS_OK};
            results_due.push_back(one_res);
        end else begin
            held.last_of_sym = 1'b1;
            results_due.push_back(held);
        end
    endfunction

    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] seen);
        if (seen !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, seen);
            errors++;
        end
    endtask

    // Driver: a new item goes out only once the previous one has been taken.
    always @(negedge aclk) begin : sender
        sym_item_t nxt;
        logic      present;
        present = s_tvalid;
        if (!aresetn) begin
            present = 1'b0;
        end else if (!s_tvalid || s_taken) begin
            present = 1'b0;
            if (symbols_pending.size() != 0 && (calm || $urandom_range(99) >= 21)) begin
                nxt = symbols_pending.pop_front();
                s_tdata <= TDATA_W'(nxt.symbol);
                s_tuser <= nxt.start;
                present = 1'b1;
            end
        end
        s_tvalid <= present;
        m_tready <= aresetn && (calm || $urandom_range(99) >= 21);
    end

    // Monitor: follows register writes and accepted items, and checks each result.
    always @(posedge aclk) begin : observer
        code_result_t due;
        s_taken = s_tvalid && s_tready;
        if (!aresetn) begin
            enc_low      = '0;
            enc_high     = BOUND_ONE;
            enc_num_syms = 3'd3;
            for (int k = 1; k <= 7; k++)
                enc_cdf[k] = CDF_ONE;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_NUM_SYMBOLS: enc_num_syms = cfg_data[SYM_W-1:0];
                    default:         enc_cdf[cfg_index] = cfg_data;
                endcase
            end
            if (s_taken)
                encode_symbol(s_tdata[SYM_W-1:0], s_tuser[0]);
            if (m_tvalid && m_tready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: result with none due, expected nothing, actual %h/%h/%b",
                             $time, m_tdata, m_tuser, m_tlast);
                    errors++;
                end else begin
                    due = results_due.pop_front();
                    check_field("code_bit", due.code_bit, m_tdata);
                    check_field("bit_present", due.bit_present, m_tuser[0]);
                    check_field("status", due.status, m_tuser[2:1]);
                    check_field("last_of_symbol", due.last_of_sym, m_tlast);
                end
            end
        end
    end

    task automatic send(input int sym, input bit start);
        sym_item_t it;
        it.symbol = sym[SYM_W-1:0];
        it.start  = start;
        symbols_pending.push_back(it);
    endtask

    // Returns at a rising edge once every item has gone in and every result has come out.
    task automatic await_idle();
        do
            @(posedge aclk);
        while (symbols_pending.size() != 0 || s_tvalid || results_due.size() != 0);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CDF_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge aclk);
        while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting();
        write_reg(REG_NUM_SYMBOLS, CDF_W'(plan_num));
        write_reg(REG_CDF_ONE,   CDF_W'(plan_cdf[1]));
        write_reg(REG_CDF_TWO,   CDF_W'(plan_cdf[2]));
        write_reg(REG_CDF_THREE, CDF_W'(plan_cdf[3]));
        write_reg(REG_CDF_FOUR,  CDF_W'(plan_cdf[4]));
        write_reg(REG_CDF_FIVE,  CDF_W'(plan_cdf[5]));
        write_reg(REG_CDF_SIX,   CDF_W'(plan_cdf[6]));
        write_reg(REG_CDF_SEVEN, CDF_W'(plan_cdf[7]));
        @(posedge aclk);
    endtask

    // A well-formed distribution over n symbols; some weights are tiny or zero so that
    // long bit runs and empty slices both occur. Words above n are left random.
    task automatic plan_monotone(input int n);
        int w [1:7];
        int total;
        int acc;
        total = 0;
        acc   = 0;
        for (int k = 1; k <= n; k++) begin
            w[k] = ($urandom_range(4) == 0) ? $urandom_range(2) : $urandom_range(1000, 1);
            total += w[k];
        end
        if (total == 0) begin
            w[n]  = 1;
            total = 1;
        end
        for (int k = 1; k <= 7; k++) begin
            if (k <= n) begin
                acc += w[k];
                plan_cdf[k] = (acc * 65536) / total;
            end else begin
                plan_cdf[k] = $urandom_range(131071);
            end
        end
        plan_num = n;
    endtask

    task automatic queue_random(input int count, input int start_pct, input int bad_pct);
        int sym;
        for (int i = 0; i < count; i++) begin
            if (plan_num == 0 || $urandom_range(99) < bad_pct)
                sym = $urandom_range(7);
            else
                sym = $urandom_range(plan_num, 1);
            send(sym, $urandom_range(99) < start_pct);
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: three symbols, every word one, so symbol 1 spans the whole
        // interval and the later ones are empty slices.
        send(1, 1'b1);
        send(2, 1'b0);
        send(3, 1'b0);
        send(0, 1'b0);
        send(4, 1'b0);
        send(7, 1'b1);
        await_idle();

        // Full alphabet with near-even slices: every symbol once, symbol 1 again, then a refused one.
        plan_num = 7;
        for (int k = 1; k <= 6; k++)
            plan_cdf[k] = k * 8192;
        plan_cdf[7] = 65536;
        apply_setting();
        for (int k = 1; k <= 7; k++)
            send(k, k == 1);
        send(1, 1'b1);
        send(0, 1'b0);
        await_idle();

        // One symbol with a word above one, which saturates, then a refused symbol.
        plan_num = 1;
        plan_cdf[1] = 131071;
        for (int k = 2; k <= 7; k++)
            plan_cdf[k] = 0;
        apply_setting();
        send(1, 1'b1);
        send(2, 1'b0);
        await_idle();

        // No symbols in use at all.
        plan_num = 0;
        apply_setting();
        send(1, 1'b0);
        await_idle();

        // A sliver just above half, then a reversed slice, then a slice of exactly half.
        plan_num = 3;
        plan_cdf[1] = 32768;
        plan_cdf[2] = 32769;
        plan_cdf[3] = 0;
        for (int k = 4; k <= 7; k++)
            plan_cdf[k] = 65536;
        apply_setting();
        send(2, 1'b1);
        send(3, 1'b1);
        send(1, 1'b1);
        await_idle();

        // The smallest non-empty slice gives the longest run of zeros.
        plan_num = 2;
        plan_cdf[1] = 1;
        plan_cdf[2] = 65536;
        apply_setting();
        send(1, 1'b1);
        send(2, 1'b1);
        await_idle();

        // Random phases. Each ends with the sender held back until the encoder has
        // drained, so the next setting is written while it is idle.
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: plan_monotone(7);
                2: plan_monotone(2);
                4: begin
                    plan_num = $urandom_range(7);
                    for (int k = 1; k <= 7; k++)
                        plan_cdf[k] = $urandom_range(131071);
                end
                default: plan_monotone($urandom_range(7, 1));
            endcase
            calm = (p == 3);
            apply_setting();
            // Without start marks the interval drifts into narrow straddles.
            queue_random(60, (p == 2) ? 0 : 6, (p == 4) ? 30 : 6);
            await_idle();
            calm = 1'b0;
        end

        if (errors == 0 && results_due.size() == 0) begin
            $display("arith_encoder_e1e2_scaling verification clean");
        end else begin
            $display("arith_encoder_e1e2_scaling verification failed");
        end
        $finish;
    end

endmodule

@@ arith_encoder_e1e2_scaling.f @@
+incdir+design
design/aenc_pkg.sv
design/aenc_cfg.sv
design/aenc_dp.sv
design/aenc_ctrl.sv
design/arith_encoder_e1e2_scaling.sv
test/testbench.sv
